>>> rtl/script_byte_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Script byte tokenizer assertion macros
// Shared concurrent assertion forms. The using module must have clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_BYTE_TOKENIZER_DEFINES_SVH
`define SCRIPT_BYTE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer package
// Types, codes, character constants and helpers shared by the tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

	localparam int LINE_BITS   = 16;
	localparam int LINE_EXT_W  = LINE_BITS + 16;
	localparam int MAX_RES     = 4;
	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_TEXT  = 2'd1,
		EV_END   = 2'd2,
		EV_ERR   = 2'd3
	} ev_kind_t;

	typedef enum logic [3:0] {
		TK_END     = 4'd0,
		TK_SLASH   = 4'd1,
		TK_OPEN    = 4'd2,
		TK_CLOSE   = 4'd3,
		TK_EQUAL   = 4'd4,
		TK_STRING  = 4'd5,
		TK_IDENT   = 4'd6,
		TK_NUMBER  = 4'd7,
		TK_UNKNOWN = 4'd8
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_UNKNOWN = 2'd1,
		ERR_STRING  = 2'd2
	} err_t;

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_COMMENT = 6'b000010,
		MODE_STRING  = 6'b000100,
		MODE_IDENT   = 6'b001000,
		MODE_INT     = 6'b010000,
		MODE_FRAC    = 6'b100000
	} mode_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] text_byte;
		tok_kind_t  token_kind;
		logic [15:0] line_no;
		err_t       err_code;
		logic       last;
	} result_t;

	// All results caused by one script byte, oldest in entry 0.
	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [2:0]            count;
	} bundle_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic result_t mk_res(input ev_kind_t k, input logic [7:0] t,
		input tok_kind_t tk, input logic [15:0] ln, input err_t e);
		result_t r;
		r.kind       = k;
		r.text_byte  = t;
		r.token_kind = tk;
		r.line_no    = ln;
		r.err_code   = e;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/sbt_ifs.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer channels
// Valid/ready channels for script bytes and for token events.
// ----------------------------------------------------------------------------
interface sbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface sbt_token_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  text_byte;
	logic [3:0]  token_kind;
	logic [15:0] line_no;
	logic [1:0]  err_code;
	logic        last;

	modport source (output valid, output kind, output text_byte, output token_kind,
		output line_no, output err_code, output last, input ready);
	modport sink (input valid, input kind, input text_byte, input token_kind,
		input line_no, input err_code, input last, output ready);
endinterface

>>> rtl/sbt_lexer.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer lexer
// Scan state and the one-step decode of a byte into its event bundle.
// ----------------------------------------------------------------------------
`include "script_byte_tokenizer_defines.svh"

module sbt_lexer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       in_byte,
	output sbt_pkg::bundle_t bundle
);

	sbt_pkg::mode_t                  mode_q, nxt_mode, bt_mode;
	logic [sbt_pkg::LINE_BITS-1:0]   line_q, nxt_line, line_inc;
	sbt_pkg::err_t                   err_q, nxt_err, bt_err;
	logic                            ended_q, nxt_ended;

	logic [sbt_pkg::LINE_EXT_W-1:0]  line_ext;
	logic [15:0]                     ln;

	sbt_pkg::result_t [2:0]          bt;
	logic [1:0]                      bt_n;
	logic                            bt_line, bt_end;
	sbt_pkg::tok_kind_t              single_tk;
	logic                            is_single;

	sbt_pkg::result_t [sbt_pkg::MAX_RES-1:0] res;
	logic [2:0]                      n;
	logic [1:0]                      last_idx;
	logic                            dispatch;

	assign line_ext = {16'b0, line_q};
	assign ln = (|line_ext[sbt_pkg::LINE_EXT_W-1:16]) ? 16'hFFFF : line_ext[15:0];
	assign line_inc = (&line_q) ? line_q : line_q + sbt_pkg::LINE_ONE;

	// Handling of a byte seen between tokens.
	always_comb begin
		bt         = '0;
		bt_n       = 2'd0;
		bt_mode    = sbt_pkg::MODE_IDLE;
		bt_line    = 1'b0;
		bt_end     = 1'b0;
		bt_err     = err_q;
		single_tk  = sbt_pkg::TK_SLASH;
		is_single  = 1'b0;
		unique case (in_byte)
			sbt_pkg::CH_NUL: begin
				bt[0]  = sbt_pkg::mk_res(sbt_pkg::EV_START, 8'h00, sbt_pkg::TK_END, ln, err_q);
				bt[1]  = sbt_pkg::mk_res(sbt_pkg::EV_END, 8'h00, sbt_pkg::TK_END, ln, err_q);
				bt_n   = 2'd2;
				bt_end = 1'b1;
			end
			sbt_pkg::CH_SLASH: begin
				is_single = 1'b1;
				single_tk = sbt_pkg::TK_SLASH;
			end
			sbt_pkg::CH_LBRACE: begin
				is_single = 1'b1;
				single_tk = sbt_pkg::TK_OPEN;
			end
			sbt_pkg::CH_RBRACE: begin
				is_single = 1'b1;
				single_tk = sbt_pkg::TK_CLOSE;
			end
			sbt_pkg::CH_EQUAL: begin
				is_single = 1'b1;
				single_tk = sbt_pkg::TK_EQUAL;
			end
			sbt_pkg::CH_HASH: begin
				bt_mode = sbt_pkg::MODE_COMMENT;
			end
			sbt_pkg::CH_QUOTE: begin
				bt[0]   = sbt_pkg::mk_res(sbt_pkg::EV_START, 8'h00, sbt_pkg::TK_STRING, ln, err_q);
				bt_n    = 2'd1;
				bt_mode = sbt_pkg::MODE_STRING;
			end
			sbt_pkg::CH_LF: begin
				bt_line = 1'b1;
			end
			sbt_pkg::CH_SPACE, sbt_pkg::CH_TAB, sbt_pkg::CH_CR: begin
				bt_n = 2'd0;
			end
			default: begin
				if (sbt_pkg::is_letter(in_byte)) begin
					bt[0]   = sbt_pkg::mk_res(sbt_pkg::EV_START, 8'h00, sbt_pkg::TK_IDENT,
						ln, err_q);
					bt[1]   = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, sbt_pkg::TK_IDENT,
						ln, err_q);
					bt_n    = 2'd2;
					bt_mode = sbt_pkg::MODE_IDENT;
				end else if (sbt_pkg::is_digit(in_byte) || in_byte == sbt_pkg::CH_MINUS) begin
					bt[0]   = sbt_pkg::mk_res(sbt_pkg::EV_START, 8'h00, sbt_pkg::TK_NUMBER,
						ln, err_q);
					bt[1]   = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, sbt_pkg::TK_NUMBER,
						ln, err_q);
					bt_n    = 2'd2;
					bt_mode = sbt_pkg::MODE_INT;
				end else begin
					// The event carries the error code itself; the error is recorded in the scan state at the edge.
					bt_err     = sbt_pkg::ERR_UNKNOWN;
					bt[0]      = sbt_pkg::mk_res(sbt_pkg::EV_ERR, in_byte,
						sbt_pkg::TK_UNKNOWN, ln, sbt_pkg::ERR_UNKNOWN);
					bt_n       = 2'd1;
				end
			end
		endcase
		if (is_single) begin
			bt[0] = sbt_pkg::mk_res(sbt_pkg::EV_START, 8'h00, single_tk, ln, err_q);
			bt[1] = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, single_tk, ln, err_q);
			bt[2] = sbt_pkg::mk_res(sbt_pkg::EV_END, 8'h00, single_tk, ln, err_q);
			bt_n  = 2'd3;
		end
	end

	// Error state first, then mode-specific handling, then the between-token path where a byte falls back to it.
	always_comb begin
		nxt_mode  = mode_q;
		nxt_line  = line_q;
		nxt_err   = err_q;
		nxt_ended = ended_q;
		res       = '0;
		n         = 3'd0;
		dispatch  = 1'b0;
		last_idx  = 2'd0;
		if (err_q != sbt_pkg::ERR_NONE) begin
			res[0] = sbt_pkg::mk_res(sbt_pkg::EV_ERR, 8'h00, sbt_pkg::TK_UNKNOWN, ln, err_q);
			n      = 3'd1;
		end else if (!ended_q) begin
			unique case (mode_q)
				sbt_pkg::MODE_COMMENT: begin
					if (in_byte == sbt_pkg::CH_NUL || in_byte == sbt_pkg::CH_LF) begin
						dispatch = 1'b1;
					end
				end
				sbt_pkg::MODE_STRING: begin
					if (in_byte == sbt_pkg::CH_QUOTE) begin
						res[0]   = sbt_pkg::mk_res(sbt_pkg::EV_END, 8'h00, sbt_pkg::TK_STRING,
							ln, err_q);
						n        = 3'd1;
						nxt_mode = sbt_pkg::MODE_IDLE;
					end else if (in_byte == sbt_pkg::CH_NUL) begin
						// Unterminated string: close it, then flag the error.
						res[0]   = sbt_pkg::mk_res(sbt_pkg::EV_END, 8'h00, sbt_pkg::TK_STRING,
							ln, err_q);
						res[1]   = sbt_pkg::mk_res(sbt_pkg::EV_ERR, 8'h00, sbt_pkg::TK_UNKNOWN,
							ln, sbt_pkg::ERR_STRING);
						n        = 3'd2;
						nxt_mode = sbt_pkg::MODE_IDLE;
						nxt_err  = sbt_pkg::ERR_STRING;
					end else begin
						res[0] = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, sbt_pkg::TK_STRING,
							ln, err_q);
						n      = 3'd1;
					end
				end
				sbt_pkg::MODE_IDENT: begin
					if (sbt_pkg::is_letter(in_byte) || sbt_pkg::is_digit(in_byte) ||
						in_byte == sbt_pkg::CH_DOT || in_byte == sbt_pkg::CH_USCORE) begin
						res[0] = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, sbt_pkg::TK_IDENT,
							ln, err_q);
						n      = 3'd1;
					end else begin
						res[0]   = sbt_pkg::mk_res(sbt_pkg::EV_END, 8'h00, sbt_pkg::TK_IDENT,
							ln, err_q);
						n        = 3'd1;
						dispatch = 1'b1;
					end
				end
				sbt_pkg::MODE_INT, sbt_pkg::MODE_FRAC: begin
					if (sbt_pkg::is_digit(in_byte)) begin
						res[0] = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, sbt_pkg::TK_NUMBER,
							ln, err_q);
						n      = 3'd1;
					end else if (in_byte == sbt_pkg::CH_DOT && mode_q == sbt_pkg::MODE_INT) begin
						res[0]   = sbt_pkg::mk_res(sbt_pkg::EV_TEXT, in_byte, sbt_pkg::TK_NUMBER,
							ln, err_q);
						n        = 3'd1;
						nxt_mode = sbt_pkg::MODE_FRAC;
					end else begin
						res[0]   = sbt_pkg::mk_res(sbt_pkg::EV_END, 8'h00, sbt_pkg::TK_NUMBER,
							ln, err_q);
						n        = 3'd1;
						dispatch = 1'b1;
					end
				end
				default: begin
					dispatch = 1'b1;
				end
			endcase
			if (dispatch) begin
				nxt_mode = bt_mode;
				nxt_err  = bt_err;
				if (bt_line) begin
					nxt_line = line_inc;
				end
				if (bt_end) begin
					nxt_ended = 1'b1;
				end
				if (n == 3'd0) begin
					res[2:0] = bt;
				end else begin
					res[3:1] = bt;
				end
				n = n + {1'b0, bt_n};
			end
		end
		if (n != 3'd0) begin
			last_idx = 2'(n - 3'd1);
			res[last_idx].last = 1'b1;
		end
		bundle.res   = res;
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sbt_pkg::MODE_IDLE;
			line_q  <= sbt_pkg::LINE_ONE;
			err_q   <= sbt_pkg::ERR_NONE;
			ended_q <= 1'b0;
		end else if (take) begin
			mode_q  <= nxt_mode;
			line_q  <= nxt_line;
			err_q   <= nxt_err;
			ended_q <= nxt_ended;
		end
	end

	`SBT_ASSERT_IMP(a_err_one_event, take && err_q != sbt_pkg::ERR_NONE, bundle.count == 3'd1, "error state must give one event per byte")
	`SBT_ASSERT_IMP(a_ended_silent, take && ended_q && err_q == sbt_pkg::ERR_NONE, bundle.count == 3'd0, "ended script must give no events")
	`SBT_ASSERT_NXT(a_open_string_err, take && err_q == sbt_pkg::ERR_NONE && !ended_q && mode_q == sbt_pkg::MODE_STRING && in_byte == sbt_pkg::CH_NUL, err_q == sbt_pkg::ERR_STRING, "open string at end must set the string error")

endmodule

>>> rtl/sbt_emit.sv
// ----------------------------------------------------------------------------
// Script byte tokenizer event emitter
// Holds a byte's event bundle and hands the events out one per beat.
// ----------------------------------------------------------------------------
`include "script_byte_tokenizer_defines.svh"

module sbt_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  sbt_pkg::bundle_t   bundle,
	output logic               can_take,
	sbt_token_if.source        events
);

	sbt_pkg::result_t                        out_q;
	logic                                    out_valid_q;
	sbt_pkg::result_t [sbt_pkg::MAX_RES-1:0] bund_q;
	logic [2:0]                              rem_q;
	logic                                    out_free;

	assign out_free = !out_valid_q || events.ready;
	assign can_take = (rem_q == 3'd0);

	// Payload: the first event of a fresh bundle goes straight to the output
	// register when it is free; everything else queues and shifts down.
	always_ff @(posedge clk) begin
		if (take && bundle.count != 3'd0) begin
			if (out_free) begin
				out_q     <= bundle.res[0];
				bund_q[0] <= bundle.res[1];
				bund_q[1] <= bundle.res[2];
				bund_q[2] <= bundle.res[3];
			end else begin
				bund_q <= bundle.res;
			end
		end else if (out_free && rem_q != 3'd0) begin
			out_q     <= bund_q[0];
			bund_q[0] <= bund_q[1];
			bund_q[1] <= bund_q[2];
			bund_q[2] <= bund_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= 3'd0;
		end else if (take && bundle.count != 3'd0) begin
			out_valid_q <= 1'b1;
			rem_q       <= out_free ? bundle.count - 3'd1 : bundle.count;
		end else if (out_free) begin
			out_valid_q <= (rem_q != 3'd0);
			if (rem_q != 3'd0) begin
				rem_q <= rem_q - 3'd1;
			end
		end
	end

	assign events.valid      = out_valid_q;
	assign events.kind       = out_q.kind;
	assign events.text_byte  = out_q.text_byte;
	assign events.token_kind = out_q.token_kind;
	assign events.line_no    = out_q.line_no;
	assign events.err_code   = out_q.err_code;
	assign events.last       = out_q.last;

	`SBT_ASSERT_IMP(a_take_when_empty, take && bundle.count != 3'd0, rem_q == 3'd0, "bundle loaded over queued events")
	`SBT_ASSERT_IMP(a_queue_needs_out, rem_q != 3'd0, out_valid_q, "queued events behind an empty output register")
	`SBT_ASSERT_IMP(a_rem_bound, 1'b1, rem_q <= 3'd4, "queue count beyond bundle size")

endmodule

>>> rtl/script_byte_tokenizer.sv
// Output: a byte's first event enters the output register at its beat if that is free.
// Throughput: one byte per cycle while each byte causes at most one event and the
// sink keeps up; a byte causing more events holds off the next until none are queued.
// Reset: arst_n clears the scan state and the event handshake at once; scanning is
// idle, line count is 1, no error is recorded, the script is not ended and no event
// is pending.
// ----------------------------------------------------------------------------
// Script byte tokenizer
// Streaming tokenizer: script bytes in, token start/text/end and error events out.
// ----------------------------------------------------------------------------
module script_byte_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	sbt_byte_if.sink    script,
	sbt_token_if.source events
);

	// The lexer decodes a byte in the cycle of its beat and updates its scan
	// state at that edge. The emitter keeps the byte's events, at most four,
	// and releases them in order behind one output register. A new byte is
	// taken only when no events are queued behind that register, so the
	// input ready is a pure register output and never waits on the sink.

	logic             take;
	logic             can_take;
	sbt_pkg::bundle_t bundle;

	assign script.ready = can_take;
	assign take         = script.valid && can_take;

	sbt_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (script.in_byte),
		.bundle  (bundle)
	);

	sbt_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.bundle   (bundle),
		.can_take (can_take),
		.events   (events)
	);

endmodule
